// File: src/osq_pkg.sv
// Shared types, codes and sizes for the ordered stack engine.
`default_nettype none

package osq_pkg;

    // Stack geometry.
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Field widths of the stream payloads.
    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = ((ACTION_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VALUE_W + STATUS_W + 7) / 8) * 8;
    localparam int VALUE_LSB  = ACTION_W;
    localparam int STATUS_LSB = VALUE_W;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // Operation codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SORT   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

    // Cell command kinds.
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_OPEN  = 2'd1;
    localparam logic [1:0] CELL_CLOSE = 2'd2;
    localparam logic [1:0] CELL_SORT  = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] pos;
        word_t            value;
        logic [CNT_W-1:0] fill;
        logic             phase;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/osq_cell.sv
// One stack cell: holds one word and trades it with its neighbors.
`default_nettype none

module osq_cell (
    input  wire logic                      clk,
    input  wire logic [osq_pkg::IDX_W-1:0] index,
    input  wire osq_pkg::cell_cmd_t        cmd,
    input  wire osq_pkg::word_t            above,
    input  wire osq_pkg::word_t            below,
    output osq_pkg::word_t                 word
);

    osq_pkg::word_t            word_reg;
    osq_pkg::word_t            word_next;
    logic [osq_pkg::CNT_W-1:0] index_ext;

    assign index_ext = osq_pkg::CNT_W'(index);

    // Next word from the broadcast command and the neighbor words.
    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.kind)
            osq_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            osq_pkg::CELL_OPEN:
            begin
                // Cells below the opened slot move down, the slot takes the new word.
                if (index > cmd.pos)
                begin
                    word_next = above;
                end
                else if (index == cmd.pos)
                begin
                    word_next = cmd.value;
                end
            end
            osq_pkg::CELL_CLOSE:
            begin
                // Cells from the closed slot down move up by one.
                if (index >= cmd.pos)
                begin
                    word_next = below;
                end
            end
            osq_pkg::CELL_SORT:
            begin
                // Odd-even transposition: the upper cell of a pair keeps the smaller word.
                // The top cell has no partner above it, so it only ever acts as an upper cell.
                if (index[0] == cmd.phase)
                begin
                    if ((index_ext + osq_pkg::CNT_W'(1)) < cmd.fill && below < word_reg)
                    begin
                        word_next = below;
                    end
                end
                else if (index != '0 && index_ext < cmd.fill && word_reg < above)
                begin
                    word_next = above;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // The stored word needs no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: src/ordered_stack_engine.sv
// Ordered stack engine: push, pop, sorted insert, remove and sort on a chain of cells.
// Push, pop, top insert, top-match remove and refused items finish in the accept cycle;
// the result goes to the output register, or to the skid register while the output is held,
// and the next item is taken at once unless the result waits in the skid register.
// Insert and remove deeper than the top scan one cell per cycle; sort runs fill_count phases.
// One item is in work at a time; a finished result may wait in a skid register.
// rst_n clears fill count, sequencer and handshake state asynchronously; cells are not reset.
`default_nettype none

module ordered_stack_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: action[2:0], value[34:3], zero fill.
    input  wire logic [osq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // Fields from bit 0: result_value[31:0], status[33:32], zero fill.
    output logic [osq_pkg::M_TDATA_W-1:0]      m_tdata
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SORT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [osq_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [osq_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                          ins_reg, ins_next;
    osq_pkg::word_t                val_reg, val_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [osq_pkg::M_TDATA_W-1:0] pend_data_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [osq_pkg::M_TDATA_W-1:0] m_tdata_reg;

    osq_pkg::cell_cmd_t            cmd;
    osq_pkg::word_t                cell_words [osq_pkg::DEPTH];

    logic                          in_fire;
    logic [osq_pkg::ACTION_W-1:0]  in_action;
    osq_pkg::word_t                in_value;
    osq_pkg::word_t                top_word;
    osq_pkg::word_t                scan_word;
    logic                          is_empty;
    logic                          is_full;
    logic                          scan_in;
    logic                          scan_lt;
    logic                          done;
    logic [osq_pkg::VALUE_W-1:0]   res_value;
    logic [osq_pkg::STATUS_W-1:0]  res_status;
    logic [osq_pkg::M_TDATA_W-1:0] res_data;
    logic                          slot_free;

    // Chain of cells, each tied to its neighbors.
    for (genvar g = 0; g < osq_pkg::DEPTH; g++)
    begin : g_cell
        osq_pkg::word_t above_w;
        osq_pkg::word_t below_w;

        if (g == 0)
        begin : g_first
            assign above_w = '0;
        end
        else
        begin : g_up
            assign above_w = cell_words[g-1];
        end

        if (g == osq_pkg::DEPTH - 1)
        begin : g_last
            assign below_w = '0;
        end
        else
        begin : g_down
            assign below_w = cell_words[g+1];
        end

        osq_cell u_cell (
            .clk   (clk),
            .index (osq_pkg::IDX_W'(g)),
            .cmd   (cmd),
            .above (above_w),
            .below (below_w),
            .word  (cell_words[g])
        );
    end

    // Input field decode and stack status.
    assign s_tready  = (state_reg == S_IDLE) && !pend_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign in_action = s_tdata[osq_pkg::ACTION_W-1:0];
    assign in_value  = osq_pkg::word_t'($signed(
                           s_tdata[osq_pkg::VALUE_LSB +: osq_pkg::VALUE_W]));
    assign top_word  = cell_words[0];
    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg == osq_pkg::CNT_W'(osq_pkg::DEPTH));
    assign scan_in   = idx_reg < fill_reg;
    assign scan_word = cell_words[idx_reg[osq_pkg::IDX_W-1:0]];
    assign scan_lt   = scan_in && (scan_word < val_reg);

    // Sequencer: decodes the operation and drives the cell command.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        ins_next   = ins_reg;
        val_next   = val_reg;
        done       = 1'b0;
        res_value  = '0;
        res_status = osq_pkg::STAT_OK;
        cmd.kind   = osq_pkg::CELL_HOLD;
        cmd.pos    = '0;
        cmd.value  = in_value;
        cmd.fill   = fill_reg;
        cmd.phase  = idx_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_action)
                        osq_pkg::ACT_PUSH:
                        begin
                            done = 1'b1;
                            if (is_full)
                            begin
                                res_status = osq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.kind  = osq_pkg::CELL_OPEN;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        osq_pkg::ACT_POP:
                        begin
                            done = 1'b1;
                            if (is_empty)
                            begin
                                res_status = osq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                res_value = osq_pkg::VALUE_W'($unsigned(top_word));
                                cmd.kind  = osq_pkg::CELL_CLOSE;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        osq_pkg::ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                done       = 1'b1;
                                res_status = osq_pkg::STAT_FULL;
                            end
                            else if (is_empty || in_value < top_word)
                            begin
                                done      = 1'b1;
                                cmd.kind  = osq_pkg::CELL_OPEN;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                ins_next   = 1'b1;
                                val_next   = in_value;
                                idx_next   = osq_pkg::CNT_W'(1);
                            end
                        end
                        osq_pkg::ACT_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                done       = 1'b1;
                                res_status = osq_pkg::STAT_EMPTY;
                            end
                            else if (top_word == in_value)
                            begin
                                done      = 1'b1;
                                cmd.kind  = osq_pkg::CELL_CLOSE;
                                fill_next = fill_reg - 1'b1;
                            end
                            else if (in_value < top_word)
                            begin
                                done       = 1'b1;
                                res_status = osq_pkg::STAT_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                ins_next   = 1'b0;
                                val_next   = in_value;
                                idx_next   = osq_pkg::CNT_W'(1);
                            end
                        end
                        osq_pkg::ACT_SORT:
                        begin
                            if (is_empty)
                            begin
                                done       = 1'b1;
                                res_status = osq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SORT;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Step down while the next word is below the operand.
                if (scan_lt)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    cmd.pos    = idx_reg[osq_pkg::IDX_W-1:0];
                    cmd.value  = val_reg;
                    if (ins_reg)
                    begin
                        cmd.kind  = osq_pkg::CELL_OPEN;
                        fill_next = fill_reg + 1'b1;
                    end
                    else if (scan_in && scan_word == val_reg)
                    begin
                        cmd.kind  = osq_pkg::CELL_CLOSE;
                        fill_next = fill_reg - 1'b1;
                    end
                    else
                    begin
                        res_status = osq_pkg::STAT_NOTFOUND;
                    end
                end
            end
            S_SORT:
            begin
                // One transposition phase per cycle, fill_count phases in all.
                cmd.kind = osq_pkg::CELL_SORT;
                if (idx_reg == fill_reg - 1'b1)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result packing and the output / skid register handoff.
    assign res_data  = osq_pkg::M_TDATA_W'({res_status, res_value});
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (slot_free)
        begin
            m_tvalid_next   = pend_valid_reg || done;
            pend_valid_next = pend_valid_reg && done;
        end
        else
        begin
            m_tvalid_next   = m_tvalid_reg;
            pend_valid_next = pend_valid_reg || done;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ins_reg <= ins_next;
        val_reg <= val_next;
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                m_tdata_reg <= pend_data_reg;
                if (done)
                begin
                    pend_data_reg <= res_data;
                end
            end
            else if (done)
            begin
                m_tdata_reg <= res_data;
            end
        end
        else if (done)
        begin
            pend_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: src/osq_checker.sv
// Port-level checks for the ordered stack engine, bound to the top level.
`default_nettype none

module osq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [osq_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Items accepted whose result transfer has not happened yet.
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_xfer && !out_xfer)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every result transfer answers an accepted item.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> outstanding_reg != 2'd0)
        else $error("result without an accepted item");

    // At most one item waits behind a held result.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 |-> !in_xfer)
        else $error("too many items in flight");

    // A failed operation carries a zero word.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[osq_pkg::STATUS_LSB +: osq_pkg::STATUS_W] != osq_pkg::STAT_OK
        |-> m_tdata[osq_pkg::VALUE_W-1:0] == '0)
        else $error("nonzero word with a failing status");

endmodule

bind ordered_stack_engine osq_checker u_osq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
